// ===== hw/rtl/fbd_pkg.sv =====
// ----------------------------------------------------------------------------
// fbd_pkg
// Shared types and constants for the four-button debouncer / event counter.
// ----------------------------------------------------------------------------
package fbd_pkg;

    localparam int CHANNELS_DEF = 4;
    localparam int PIN_W        = 4;
    localparam int CH_W         = 2;
    localparam int CNT_W        = 8;
    localparam int START_CH     = 1;

    localparam logic [CNT_W-1:0] EVENT_MAX    = 8'd255;
    localparam logic [CNT_W-1:0] THRESH_RESET = 8'd2;

    localparam logic CMD_SCAN = 1'b0;
    localparam logic CMD_TAKE = 1'b1;

    typedef struct packed {
        logic             cmd;
        logic [PIN_W-1:0] pin_levels;
        logic [CH_W-1:0]  channel;
    } t_in_item;

    typedef struct packed {
        logic             event_taken;
        logic [PIN_W-1:0] stable_state;
        logic [CNT_W-1:0] pending_count;
    } t_out_item;

    // per-lane control for one transaction
    typedef struct packed {
        logic tick;
        logic take;
        logic pressed;
    } t_lane_ctl;

    // per-lane status after the transaction
    typedef struct packed {
        logic             stable;
        logic [CNT_W-1:0] events;
        logic             taken;
    } t_lane_st;

endpackage

// ===== hw/rtl/four_button_debouncer_event_counter.sv =====
// ----------------------------------------------------------------------------
// four_button_debouncer_event_counter
// Per-channel button debouncing with saturating event counters.
// ----------------------------------------------------------------------------
// Takes one transaction per clock: a scan tick (all channels sample their
// active-low pin at once, one lane per channel) or a take command for one
// channel. The result appears in the output register on the cycle after the
// input transaction; the input stays ready while that register is empty or
// being drained, so throughput is one item per cycle.
// The threshold register can be written at any time (its ready is always high)
// and takes effect on the next scan tick; a threshold of zero acts like one.
module four_button_debouncer_event_counter #(
    parameter int CHANNELS = fbd_pkg::CHANNELS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  fbd_pkg::t_in_item         i_in_data,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output fbd_pkg::t_out_item        o_out_data,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [fbd_pkg::CNT_W-1:0] i_cfg_data
);
    import fbd_pkg::*;

    logic [CNT_W-1:0] r_threshold;
    logic             accept;
    t_lane_ctl        lane_ctl [CHANNELS];
    t_lane_st         lane_st  [CHANNELS];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESH_RESET;
        end else if (i_cfg_valid) begin
            r_threshold <= i_cfg_data;
        end
    end

    assign accept = i_in_valid && o_in_ready;

    for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
        always_comb begin
            lane_ctl[g].tick = accept && (i_in_data.cmd == CMD_SCAN);
            lane_ctl[g].take = accept && (i_in_data.cmd == CMD_TAKE)
                               && (32'(i_in_data.channel) == g);
            // channels past the pin field read as pressed
            if (g < PIN_W) begin
                lane_ctl[g].pressed = !i_in_data.pin_levels[g % PIN_W];
            end else begin
                lane_ctl[g].pressed = 1'b1;
            end
        end

        fbd_lane #(
            .IS_START (g == START_CH)
        ) u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_thresh (r_threshold),
            .i_ctl    (lane_ctl[g]),
            .o_st     (lane_st[g])
        );
    end

    fbd_merge #(
        .CHANNELS (CHANNELS)
    ) u_merge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (accept),
        .i_channel    (i_in_data.channel),
        .i_lane       (lane_st),
        .o_load_ready (o_in_ready),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_data   (o_out_data)
    );

endmodule

// ===== hw/rtl/fbd_lane.sv =====
// ----------------------------------------------------------------------------
// fbd_lane
// One button channel: debounce counter, stable state and saturating event count.
// ----------------------------------------------------------------------------
module fbd_lane #(
    parameter bit IS_START = 1'b0
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [fbd_pkg::CNT_W-1:0]  i_thresh,
    input  fbd_pkg::t_lane_ctl         i_ctl,
    output fbd_pkg::t_lane_st          o_st
);
    import fbd_pkg::*;

    logic             r_stable, n_stable;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [CNT_W-1:0] r_events, n_events;
    logic             r_armed, n_armed;
    logic [CNT_W-1:0] cnt_inc;
    logic             taken;

    always_comb begin
        n_stable = r_stable;
        n_cnt    = r_cnt;
        n_events = r_events;
        n_armed  = r_armed;
        taken    = 1'b0;
        cnt_inc  = r_cnt + 8'd1;
        if (i_ctl.tick) begin
            if (i_ctl.pressed == r_stable) begin
                n_cnt = '0;
            end else if (cnt_inc < i_thresh) begin
                n_cnt = cnt_inc;
            end else begin
                // change confirmed
                n_cnt    = '0;
                n_stable = i_ctl.pressed;
                if (IS_START) begin
                    if (i_ctl.pressed) begin
                        n_armed = 1'b1;
                    end else if (r_armed) begin
                        n_armed = 1'b0;
                        if (r_events != EVENT_MAX) begin
                            n_events = r_events + 8'd1;
                        end
                    end
                end else if (i_ctl.pressed && r_events != EVENT_MAX) begin
                    n_events = r_events + 8'd1;
                end
            end
        end else if (i_ctl.take && r_events != '0) begin
            n_events = r_events - 8'd1;
            taken    = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable <= 1'b0;
            r_cnt    <= '0;
            r_events <= '0;
            r_armed  <= 1'b0;
        end else begin
            r_stable <= n_stable;
            r_cnt    <= n_cnt;
            r_events <= n_events;
            r_armed  <= n_armed;
        end
    end

    // status reflects the state after this transaction
    assign o_st.stable = n_stable;
    assign o_st.events = n_events;
    assign o_st.taken  = taken;

endmodule

// ===== hw/rtl/fbd_merge.sv =====
// ----------------------------------------------------------------------------
// fbd_merge
// Combines lane status into one result and holds it in the output register.
// ----------------------------------------------------------------------------
module fbd_merge #(
    parameter int CHANNELS = fbd_pkg::CHANNELS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_load,
    input  logic [fbd_pkg::CH_W-1:0]  i_channel,
    input  fbd_pkg::t_lane_st         i_lane [CHANNELS],
    output logic                      o_load_ready,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output fbd_pkg::t_out_item        o_out_data
);
    import fbd_pkg::*;

    t_out_item n_res;
    t_out_item r_res;
    logic      r_valid;

    always_comb begin
        n_res = '0;
        for (int i = 0; i < CHANNELS; i++) begin
            if (i < PIN_W) begin
                n_res.stable_state[i] = i_lane[i].stable;
            end
            if (32'(i_channel) == i) begin
                n_res.pending_count = i_lane[i].events;
            end
            n_res.event_taken = n_res.event_taken | i_lane[i].taken;
        end
    end

    assign o_load_ready = !r_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_res;

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for four_button_debouncer_event_counter. A local
// predictor tracks debounce counters, stable states, the start-channel arm
// flag and the saturating event counts. It computes the expected result for
// every accepted scan tick or take. Each named test covers one behavior. Both
// sides idle at random, and some stretches run with no idling at all.
// ----------------------------------------------------------------------------
module tb;
    import fbd_pkg::*;

    localparam int NCH         = CHANNELS_DEF;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int MAX_REPORTS = 10;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    t_in_item   i_in_data;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    t_out_item  o_out_data;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [CNT_W-1:0] i_cfg_data;

    // predictor state
    logic             btn_stable  [NCH];
    logic [CNT_W-1:0] btn_dbc_cnt [NCH];
    logic [CNT_W-1:0] btn_events  [NCH];
    logic             start_armed;
    logic [CNT_W-1:0] dbc_threshold;

    t_out_item btn_result_q[$];

    int  mismatch_cnt = 0;
    int  cycle_cnt    = 0;
    bit  tx_gap_en    = 1'b0;
    bit  rx_stall_en  = 1'b0;
    int  rx_stall_left = 0;
    int  rx_hold_cycles = 0;

    four_button_debouncer_event_counter u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic void add_event(int ch);
        if (btn_events[ch] != EVENT_MAX)
            btn_events[ch] = btn_events[ch] + 1'b1;
    endfunction

    function automatic t_out_item predict_buttons(t_in_item it);
        t_out_item        r;
        logic             pressed;
        logic [CNT_W-1:0] next_cnt;
        r = '0;
        if (it.cmd == CMD_SCAN) begin
            for (int i = 0; i < NCH; i++) begin
                pressed = ~it.pin_levels[i];
                if (pressed == btn_stable[i]) begin
                    btn_dbc_cnt[i] = '0;
                end else begin
                    next_cnt = btn_dbc_cnt[i] + 1'b1;
                    // threshold 0 falls through here too: one sample confirms
                    if (next_cnt < dbc_threshold) begin
                        btn_dbc_cnt[i] = next_cnt;
                    end else begin
                        btn_dbc_cnt[i] = '0;
                        btn_stable[i]  = pressed;
                        if (i == START_CH) begin
                            if (pressed) begin
                                start_armed = 1'b1;
                            end else if (start_armed) begin
                                start_armed = 1'b0;
                                add_event(i);
                            end
                        end else if (pressed) begin
                            add_event(i);
                        end
                    end
                end
            end
        end else if (btn_events[it.channel] != '0) begin
            btn_events[it.channel] = btn_events[it.channel] - 1'b1;
            r.event_taken = 1'b1;
        end
        for (int i = 0; i < NCH; i++)
            r.stable_state[i] = btn_stable[i];
        r.pending_count = btn_events[it.channel];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // result checking and receiver side
    // ------------------------------------------------------------------
    task automatic note_mismatch(input string field, input int exp_v, input int act_v);
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
            $display("mismatch %0s: expected %0d, got %0d (cycle %0d)",
                     field, exp_v, act_v, cycle_cnt);
    endtask

    always @(posedge i_clk) begin
        t_out_item exp_r;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_ready) begin
            if (btn_result_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= MAX_REPORTS)
                    $display("unexpected result transaction (cycle %0d)", cycle_cnt);
            end else begin
                exp_r = btn_result_q.pop_front();
                if (o_out_data.event_taken !== exp_r.event_taken)
                    note_mismatch("event_taken", int'(exp_r.event_taken),
                                  int'(o_out_data.event_taken));
                if (o_out_data.stable_state !== exp_r.stable_state)
                    note_mismatch("stable_state", int'(exp_r.stable_state),
                                  int'(o_out_data.stable_state));
                if (o_out_data.pending_count !== exp_r.pending_count)
                    note_mismatch("pending_count", int'(exp_r.pending_count),
                                  int'(o_out_data.pending_count));
            end
            if (rx_stall_en)
                rx_stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
        end
    end

    always @(negedge i_clk) begin
        if (rx_hold_cycles > 0) begin
            rx_hold_cycles--;
            i_out_ready <= 1'b0;
        end else if (rx_stall_left > 0) begin
            rx_stall_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------
    function automatic t_in_item make_item(logic cmd, logic [PIN_W-1:0] pins,
                                           logic [CH_W-1:0] ch);
        t_in_item it;
        it.cmd        = cmd;
        it.pin_levels = pins;
        it.channel    = ch;
        return it;
    endfunction

    task automatic send_item(input t_in_item it);
        int gap;
        gap = tx_gap_en ? $urandom_range(0, 16) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        btn_result_q.push_back(predict_buttons(it));
    endtask

    task automatic send_ticks(input logic [PIN_W-1:0] pins, input int n);
        repeat (n) send_item(make_item(CMD_SCAN, pins, CH_W'($urandom_range(0, 3))));
    endtask

    task automatic send_take(input logic [CH_W-1:0] ch);
        send_item(make_item(CMD_TAKE, PIN_W'($urandom_range(0, 15)), ch));
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (btn_result_q.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_threshold(input logic [CNT_W-1:0] value);
        wait_idle();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        dbc_threshold = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_directed_basics();
        // takes with nothing pending
        for (int c = 0; c < NCH; c++) send_take(CH_W'(c));
        send_ticks(4'b0000, 2);   // press all, start arms
        send_ticks(4'b1111, 2);   // release all, start records
        for (int c = 0; c < NCH; c++) send_take(CH_W'(c));
        send_take(CH_W'(0));
        // bounce: differing sample then agreeing one clears the count
        send_ticks(4'b0110, 1);
        send_ticks(4'b1111, 1);
        send_ticks(4'b1001, 2);
        send_ticks(4'b1111, 2);
        send_take(CH_W'(2));
        send_take(CH_W'(1));
    endtask

    task automatic test_threshold_extremes();
        write_threshold(8'd0);
        send_ticks(4'b1010, 1);
        send_ticks(4'b1111, 1);
        send_take(CH_W'(0));
        send_take(CH_W'(2));
        write_threshold(8'd255);
        send_ticks(4'b0000, 100);
        send_ticks(4'b1111, 1);
        send_ticks(4'b0000, 255);
        send_take(CH_W'(3));
        write_threshold(8'd1);
        send_ticks(4'b1111, 1);
        send_take(CH_W'(1));
        send_take(CH_W'(1));
    endtask

    task automatic test_output_backpressure();
        wait_idle();
        rx_hold_cycles = 200;
        tx_gap_en = 1'b0;
        for (int n = 0; n < 40; n++) begin
            if (n % 3 == 0)
                send_take(CH_W'($urandom_range(0, 3)));
            else
                send_ticks(PIN_W'($urandom_range(0, 15)), 1);
        end
        wait_idle();
    endtask

    task automatic random_phase(input int count);
        int left, pick, thr_eff, hold;
        logic [PIN_W-1:0] target;
        left = count;
        while (left > 0) begin
            pick = $urandom_range(0, 9);
            if (pick < 2) begin
                send_item(make_item(1'($urandom_range(0, 1)), PIN_W'($urandom_range(0, 15)),
                                    CH_W'($urandom_range(0, 3))));
                left--;
            end else if (pick < 4) begin
                send_take(CH_W'($urandom_range(0, 3)));
                left--;
            end else begin
                // bounce, then hold a pattern long enough (usually) to confirm
                repeat ($urandom_range(0, 3)) begin
                    send_ticks(PIN_W'($urandom_range(0, 15)), 1);
                    left--;
                end
                target  = PIN_W'($urandom_range(0, 15));
                thr_eff = (dbc_threshold == 0) ? 1 : int'(dbc_threshold);
                hold    = ($urandom_range(0, 4) == 0) ? thr_eff - 1
                                                      : thr_eff + $urandom_range(0, 2);
                send_ticks(target, hold);
                left -= hold;
            end
        end
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 8; phase++) begin
            write_threshold((phase == 0) ? 8'd1 : CNT_W'($urandom_range(0, 6)));
            tx_gap_en   = (phase != 0) && (phase != 4);
            rx_stall_en = (phase != 0) && (phase != 5);
            random_phase(65);
            // sender pause until all results are back
            wait_idle();
            random_phase(65);
        end
        tx_gap_en   = 1'b0;
        rx_stall_en = 1'b0;
    endtask

    task automatic test_event_saturation();
        write_threshold(8'd1);
        rx_stall_en = 1'b1;
        repeat (262) begin
            send_ticks(4'b0000, 1);
            send_ticks(4'b1111, 1);
        end
        for (int c = 0; c < NCH; c++) begin
            send_take(CH_W'(c));
            send_take(CH_W'(c));
        end
        // refill to the ceiling and confirm the drop
        send_ticks(4'b0000, 1);
        send_ticks(4'b1111, 1);
        send_ticks(4'b0000, 1);
        send_ticks(4'b1111, 1);
        send_ticks(4'b0000, 1);
        send_ticks(4'b1111, 1);
        for (int c = 0; c < NCH; c++) send_take(CH_W'(c));
        rx_stall_en = 1'b0;
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        for (int i = 0; i < NCH; i++) begin
            btn_stable[i]  = 1'b0;
            btn_dbc_cnt[i] = '0;
            btn_events[i]  = '0;
        end
        start_armed   = 1'b0;
        dbc_threshold = THRESH_RESET;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_basics();
        test_threshold_extremes();
        test_output_backpressure();
        test_random_traffic();
        test_event_saturation();

        wait_idle();
        repeat (10) @(posedge i_clk);
        if (btn_result_q.size() != 0)
            mismatch_cnt++;
        if (mismatch_cnt == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/fbd_pkg.sv
hw/rtl/fbd_lane.sv
hw/rtl/fbd_merge.sv
hw/rtl/four_button_debouncer_event_counter.sv
verif/tb.sv
